// ----- hw/rtl/cesv_pkg.sv -----
package cesv_pkg;

  typedef enum logic [4:0] {
    SEC_VERSION   = 5'd0,
    SEC_SEED      = 5'd1,
    SEC_FLAGS     = 5'd2,
    SEC_INCNT     = 5'd3,
    SEC_OUTCNT    = 5'd4,
    SEC_SCANCNT   = 5'd5,
    SEC_HLABCNT   = 5'd6,
    SEC_TXID      = 5'd7,
    SEC_VOUT      = 5'd8,
    SEC_ITYPE     = 5'd9,
    SEC_PREV_LEN  = 5'd10,
    SEC_PREV      = 5'd11,
    SEC_SIG_LEN   = 5'd12,
    SEC_SIG       = 5'd13,
    SEC_WIT_LEN   = 5'd14,
    SEC_WIT       = 5'd15,
    SEC_PRIV      = 5'd16,
    SEC_PUB       = 5'd17,
    SEC_SCANPUB   = 5'd18,
    SEC_SPENDPUB  = 5'd19,
    SEC_RCPTCNT   = 5'd20,
    SEC_OUTKEY    = 5'd21,
    SEC_SCANPRIV  = 5'd22,
    SEC_SPENDPRIV = 5'd23,
    SEC_V1LABCNT  = 5'd24,
    SEC_LABEL     = 5'd25,
    SEC_END       = 5'd26
  } sec_e;

  typedef enum logic [3:0] {
    ST_BUSY      = 4'd0,
    ST_OK        = 4'd1,
    ST_EARLY     = 4'd2,
    ST_VERSION   = 4'd3,
    ST_FLAGS     = 4'd4,
    ST_GRP_CNT   = 4'd5,
    ST_SCAN_CNT  = 4'd6,
    ST_LAB_CNT   = 4'd7,
    ST_TYPE      = 4'd8,
    ST_IN_KEY    = 4'd9,
    ST_V1_KEY    = 4'd10,
    ST_V2_KEY    = 4'd11,
    ST_ZERO_RCPT = 4'd12,
    ST_TRAILING  = 4'd13
  } status_e;

  typedef struct packed {
    logic [3:0]  status;
    logic [4:0]  section;
    logic [15:0] offset;
    logic [7:0]  value;
    logic        done;
  } result_t;

  function automatic logic [15:0] field_len(input logic [4:0] ph);
    case (ph)
      5'd0, 5'd9: field_len = 16'd1;
      5'd1: field_len = 16'd8;
      5'd2, 5'd8, 5'd25: field_len = 16'd4;
      5'd3, 5'd4, 5'd5, 5'd6, 5'd10, 5'd12, 5'd14, 5'd20, 5'd24: field_len = 16'd2;
      5'd7, 5'd16, 5'd21, 5'd22, 5'd23: field_len = 16'd32;
      5'd17, 5'd18, 5'd19: field_len = 16'd33;
      default: field_len = 16'd0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/cesv_core.sv -----
module cesv_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output cesv_pkg::result_t   res_o
);

  logic [4:0]  phase_q, phase_d;
  logic [1:0]  ver_q, ver_d;
  logic [8:0]  flags_q, flags_d;
  logic [15:0] left_q, left_d, pos_q, pos_d;
  logic [31:0] asm_q, asm_d;
  logic [15:0] inl_q, inl_d, grp_q, grp_d, scn_q, scn_d, lab_q, lab_d;
  logic [3:0]  err_q, err_d;
  logic        pend_q, pend_d;

  // Next-field chain decisions are evaluated on the updated counters.
  always_comb begin
    logic [4:0]  ph;
    logic [15:0] off, c16;
    logic [31:0] v;
    logic        badkey, done, go;
    logic [4:0]  nx;
    logic [15:0] n16;
    phase_d = phase_q; ver_d = ver_q; flags_d = flags_q; left_d = left_q;
    pos_d = pos_q; asm_d = asm_q; inl_d = inl_q; grp_d = grp_q; scn_d = scn_q;
    lab_d = lab_q; err_d = err_q; pend_d = pend_q;
    ph = phase_q; off = pos_q; v = '0; c16 = '0; badkey = 1'b0; done = 1'b0;
    nx = cesv_pkg::SEC_END; n16 = '0; go = 1'b0;
    res_o.section = cesv_pkg::SEC_END;
    res_o.offset  = '0;
    if (err_q != cesv_pkg::ST_BUSY || phase_q >= cesv_pkg::SEC_END) begin
      if (err_q == cesv_pkg::ST_BUSY) err_d = cesv_pkg::ST_TRAILING;
    end else begin
      res_o.section = ph;
      res_o.offset  = off;
      v = asm_q;
      case (off)
        16'd0: v[7:0]   = byte_i;
        16'd1: v[15:8]  = byte_i;
        16'd2: v[23:16] = byte_i;
        16'd3: v[31:24] = byte_i;
        default: ;
      endcase
      asm_d = v;
      c16 = v[15:0];
      if (off == 16'd0) begin
        badkey = !(byte_i == 8'h02 || byte_i == 8'h03);
        if (ph == cesv_pkg::SEC_PUB || ph == cesv_pkg::SEC_SCANPUB) pend_d = badkey;
        else if (ph == cesv_pkg::SEC_SPENDPUB) pend_d = pend_q | badkey;
      end
      pos_d  = pos_q + 16'd1;
      left_d = left_q - 16'd1;
      done = (left_d == 16'd0);
      if (done) begin
        // go=1 means: enter fixed field nx; otherwise phase becomes a length-prefixed body, END or error.
        // Chain decisions are flattened: compute the "from" for the input chain.
        logic chain; logic [4:0] from; logic endin; logic aft_in, aft_grp, aft_scn, tolab;
        chain = 1'b0; from = '0; endin = 1'b0; aft_in = 1'b0; aft_grp = 1'b0;
        aft_scn = 1'b0; tolab = 1'b0;
        case (ph)
          cesv_pkg::SEC_VERSION: if (v == 32'd1 || v == 32'd2) begin
            ver_d = v[1:0]; nx = cesv_pkg::SEC_SEED; go = 1'b1;
          end else err_d = cesv_pkg::ST_VERSION;
          cesv_pkg::SEC_SEED: begin nx = cesv_pkg::SEC_FLAGS; go = 1'b1; end
          cesv_pkg::SEC_FLAGS: begin
            flags_d = v[8:0];
            pend_d = (ver_q == 2'd1) ? (v[31:3] != '0) : (v[31:9] != '0);
            nx = cesv_pkg::SEC_INCNT; go = 1'b1;
          end
          cesv_pkg::SEC_INCNT: begin
            inl_d = c16; nx = cesv_pkg::SEC_OUTCNT; go = 1'b1;
          end
          cesv_pkg::SEC_OUTCNT: if (ver_q == 2'd1) begin
            if (pend_q) err_d = cesv_pkg::ST_FLAGS;
            else if (inl_q != '0) begin nx = cesv_pkg::SEC_TXID; go = 1'b1; end
            else aft_in = 1'b1;
          end else begin
            grp_d = c16; nx = cesv_pkg::SEC_SCANCNT; go = 1'b1;
          end
          cesv_pkg::SEC_SCANCNT: begin
            scn_d = c16; nx = cesv_pkg::SEC_HLABCNT; go = 1'b1;
          end
          cesv_pkg::SEC_HLABCNT: begin
            lab_d = c16;
            if (pend_q) err_d = cesv_pkg::ST_FLAGS;
            else if (!flags_q[6] && grp_q != '0) err_d = cesv_pkg::ST_GRP_CNT;
            else if (!flags_q[7] && scn_q != '0) err_d = cesv_pkg::ST_SCAN_CNT;
            else if (!flags_q[8] && c16 != '0) err_d = cesv_pkg::ST_LAB_CNT;
            else if (inl_q != '0) begin nx = cesv_pkg::SEC_TXID; go = 1'b1; end
            else aft_in = 1'b1;
          end
          cesv_pkg::SEC_TXID: begin nx = cesv_pkg::SEC_VOUT; go = 1'b1; end
          cesv_pkg::SEC_VOUT: begin nx = cesv_pkg::SEC_ITYPE; go = 1'b1; end
          cesv_pkg::SEC_ITYPE: if (v >= 32'd1 && v <= ((ver_q == 2'd1) ? 32'd3 : 32'd4)) begin
            chain = 1'b1; from = cesv_pkg::SEC_PREV_LEN;
          end else err_d = cesv_pkg::ST_TYPE;
          cesv_pkg::SEC_PREV_LEN, cesv_pkg::SEC_SIG_LEN, cesv_pkg::SEC_WIT_LEN:
            if (c16 != '0) begin
              phase_d = ph + 5'd1; left_d = c16; pos_d = '0; asm_d = '0;
            end else begin chain = 1'b1; from = ph + 5'd2; end
          cesv_pkg::SEC_PREV, cesv_pkg::SEC_SIG, cesv_pkg::SEC_WIT: begin
            chain = 1'b1; from = ph + 5'd1;
          end
          cesv_pkg::SEC_PRIV: begin chain = 1'b1; from = cesv_pkg::SEC_PUB; end
          cesv_pkg::SEC_PUB: if (pend_d) err_d = cesv_pkg::ST_IN_KEY;
          else endin = 1'b1;
          cesv_pkg::SEC_SCANPUB: begin nx = cesv_pkg::SEC_SPENDPUB; go = 1'b1; end
          cesv_pkg::SEC_SPENDPUB: if (ver_q == 2'd1) begin
            if (pend_d) err_d = cesv_pkg::ST_V1_KEY;
            else begin nx = cesv_pkg::SEC_V1LABCNT; go = 1'b1; end
          end else begin nx = cesv_pkg::SEC_RCPTCNT; go = 1'b1; end
          cesv_pkg::SEC_RCPTCNT: if (pend_q) err_d = cesv_pkg::ST_V2_KEY;
          else if (c16 == '0) err_d = cesv_pkg::ST_ZERO_RCPT;
          else begin
            grp_d = grp_q - 16'd1;
            if (grp_d != '0) begin
              pend_d = 1'b0; nx = cesv_pkg::SEC_SCANPUB; go = 1'b1;
            end else aft_grp = 1'b1;
          end
          cesv_pkg::SEC_OUTKEY: begin
            scn_d = scn_q - 16'd1;
            if (scn_d != '0) begin nx = cesv_pkg::SEC_OUTKEY; go = 1'b1; end
            else aft_scn = 1'b1;
          end
          cesv_pkg::SEC_SCANPRIV: begin nx = cesv_pkg::SEC_SPENDPRIV; go = 1'b1; end
          cesv_pkg::SEC_SPENDPRIV: tolab = 1'b1;
          cesv_pkg::SEC_V1LABCNT: begin lab_d = c16; tolab = 1'b1; end
          cesv_pkg::SEC_LABEL: begin
            lab_d = lab_q - 16'd1;
            if (lab_d != '0) begin nx = cesv_pkg::SEC_LABEL; go = 1'b1; end
            else phase_d = cesv_pkg::SEC_END;
          end
          default: phase_d = cesv_pkg::SEC_END;
        endcase
        if (chain) begin
          if (from <= cesv_pkg::SEC_PREV_LEN && flags_q[3]) begin
            nx = cesv_pkg::SEC_PREV_LEN; go = 1'b1;
          end else if (from <= cesv_pkg::SEC_SIG_LEN && flags_q[4]) begin
            nx = cesv_pkg::SEC_SIG_LEN; go = 1'b1;
          end else if (from <= cesv_pkg::SEC_WIT_LEN && flags_q[5]) begin
            nx = cesv_pkg::SEC_WIT_LEN; go = 1'b1;
          end else if (from <= cesv_pkg::SEC_PRIV && flags_q[1]) begin
            nx = cesv_pkg::SEC_PRIV; go = 1'b1;
          end else if (from <= cesv_pkg::SEC_PUB && flags_q[2]) begin
            nx = cesv_pkg::SEC_PUB; go = 1'b1;
          end else endin = 1'b1;
        end
        if (endin) begin
          inl_d = inl_q - 16'd1;
          if (inl_d != '0) begin nx = cesv_pkg::SEC_TXID; go = 1'b1; end
          else aft_in = 1'b1;
        end
        if (aft_in) begin
          if (ver_q == 2'd1 || (flags_q[6] && grp_q != '0)) begin
            pend_d = 1'b0; nx = cesv_pkg::SEC_SCANPUB; go = 1'b1;
          end else aft_grp = 1'b1;
        end
        if (aft_grp) begin
          if (flags_q[7] && scn_q != '0) begin nx = cesv_pkg::SEC_OUTKEY; go = 1'b1; end
          else aft_scn = 1'b1;
        end
        if (aft_scn) begin
          if (flags_q[8]) begin nx = cesv_pkg::SEC_SCANPRIV; go = 1'b1; end
          else tolab = 1'b1;
        end
        if (tolab) begin
          if (lab_d != '0) begin nx = cesv_pkg::SEC_LABEL; go = 1'b1; end
          else phase_d = cesv_pkg::SEC_END;
        end
        if (go) begin
          phase_d = nx; left_d = cesv_pkg::field_len(nx); pos_d = '0; asm_d = '0;
        end
        if (err_d != err_q) phase_d = cesv_pkg::SEC_END;
      end
    end
    res_o.status = err_d;
    if (last_i && err_d == cesv_pkg::ST_BUSY)
      res_o.status = (phase_d >= cesv_pkg::SEC_END) ? cesv_pkg::ST_OK : cesv_pkg::ST_EARLY;
    res_o.value = byte_i;
    res_o.done  = last_i;
    n16 = '0;
    if (last_i) begin
      phase_d = cesv_pkg::SEC_VERSION; ver_d = '0; flags_d = '0; left_d = 16'd1;
      pos_d = n16; asm_d = '0; inl_d = '0; grp_d = '0; scn_d = '0; lab_d = '0;
      err_d = cesv_pkg::ST_BUSY; pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cesv_pkg::SEC_VERSION; ver_q <= '0; flags_q <= '0; left_q <= 16'd1;
      pos_q <= '0; asm_q <= '0; inl_q <= '0; grp_q <= '0; scn_q <= '0; lab_q <= '0;
      err_q <= cesv_pkg::ST_BUSY; pend_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; ver_q <= ver_d; flags_q <= flags_d; left_q <= left_d;
      pos_q <= pos_d; asm_q <= asm_d; inl_q <= inl_d; grp_q <= grp_d; scn_q <= scn_d;
      lab_q <= lab_d; err_q <= err_d; pend_q <= pend_d;
    end
  end

  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != cesv_pkg::ST_BUSY) |-> (phase_q == cesv_pkg::SEC_END)) else $error("err phase");
  a_err_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !last_i && err_q != cesv_pkg::ST_BUSY) |=> ($past(err_q) == err_q))
    else $error("err not held");
  a_phase_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= cesv_pkg::SEC_END) else $error("phase range");

endmodule

// ----- hw/rtl/case_envelope_stream_validator_top.sv -----
// Validates a binary test-case envelope one byte per item. Each accepted byte yields one
// result item carrying its status, section tag, offset within field, the echoed byte and a
// done flag copied from tlast. Throughput is one item per clock: the parse update is a single
// combinational step between the state registers, and one output register decouples the
// master side, so a new byte is taken whenever the output register is empty or being drained.
// The input side stalls only while a result waits in the output register and the master side
// does not take it. The result of a byte accepted at one edge is offered on the master side
// right after that edge.
module case_envelope_stream_validator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] payload_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [3:0] status, [8:4] section,
                                        // [24:9] offset_in_field, [32:25] byte_value,
                                        // [39:33] zero
  output logic        m_axis_tlast_o    // done_res
);

  cesv_pkg::result_t res;
  logic step;
  logic        vld_q;
  logic [32:0] data_q;
  logic        last_q;

  // The output register is free when empty or emptied in this cycle.
  assign s_axis_tready_o = !vld_q || m_axis_tready_i;
  assign step = s_axis_tvalid_i && s_axis_tready_o;

  cesv_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      data_q <= {res.value, res.offset, res.section, res.status};
      last_q <= res.done;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {7'd0, data_q};
  assign m_axis_tlast_o  = last_q;

endmodule

// ----- tb/case_envelope_stream_validator_top_tb.sv -----
module case_envelope_stream_validator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  case_envelope_stream_validator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Pending bytes for the driver, each entry is {last, byte}.
  logic [8:0]  byte_q[$];
  logic [7:0]  env_buf[$];
  cesv_pkg::result_t expected_q[$];
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_errors = 0;
  int          n_cycles = 0;
  bit          stim_done = 1'b0;

  // Shadow copy of the parser state.
  logic [4:0]  ph_q;
  logic [1:0]  ver_q;
  logic [8:0]  flags_q;
  logic [15:0] left_q;
  logic [15:0] pos_q;
  logic [31:0] acc_q;
  logic [15:0] n_in, n_grp, n_scan, n_lab;
  logic [3:0]  err_q;
  bit          bad_q;

  // Byte length of each fixed-size field; length-prefixed bodies are sized at run time.
  logic [15:0] seg_len_tab [0:25] = '{1, 8, 4, 2, 2, 2, 2, 32, 4, 1, 2, 0, 2, 0, 2, 0,
                                      32, 33, 33, 33, 2, 32, 32, 32, 2, 4};

  // Queue appends.
  task automatic add_env(input logic [7:0] b);
    env_buf.insert(env_buf.size(), b);
  endtask

  task automatic add_pending(input logic [8:0] e);
    byte_q.insert(byte_q.size(), e);
  endtask

  task automatic parser_clear();
    ph_q = cesv_pkg::SEC_VERSION; ver_q = '0; flags_q = '0; left_q = 16'd1; pos_q = '0;
    acc_q = '0; n_in = '0; n_grp = '0; n_scan = '0; n_lab = '0; err_q = cesv_pkg::ST_BUSY;
    bad_q = 1'b0;
  endtask

  task automatic reject(input logic [3:0] code);
    err_q = code;
    ph_q = cesv_pkg::SEC_END;
  endtask

  task automatic enter(input logic [4:0] p, input logic [15:0] len);
    ph_q = p; left_q = len; pos_q = '0; acc_q = '0;
  endtask

  task automatic enter_fixed(input logic [4:0] p);
    enter(p, seg_len_tab[p]);
  endtask

  task automatic go_labels();
    if (n_lab != 0) enter_fixed(cesv_pkg::SEC_LABEL);
    else ph_q = cesv_pkg::SEC_END;
  endtask

  task automatic go_after_scans();
    if (flags_q[8]) enter_fixed(cesv_pkg::SEC_SCANPRIV);
    else go_labels();
  endtask

  task automatic go_after_groups();
    if (flags_q[7] && n_scan != 0) enter_fixed(cesv_pkg::SEC_OUTKEY);
    else go_after_scans();
  endtask

  task automatic go_after_inputs();
    if (ver_q == 2'd1 || (flags_q[6] && n_grp != 0)) begin
      bad_q = 1'b0;
      enter_fixed(cesv_pkg::SEC_SCANPUB);
    end else begin
      go_after_groups();
    end
  endtask

  task automatic close_input();
    n_in = n_in - 16'd1;
    if (n_in != 0) enter_fixed(cesv_pkg::SEC_TXID);
    else go_after_inputs();
  endtask

  // Moves to the next optional field of an input record that is enabled, starting at from.
  task automatic next_in_field(input logic [4:0] from);
    if (from <= cesv_pkg::SEC_PREV_LEN && flags_q[3]) enter_fixed(cesv_pkg::SEC_PREV_LEN);
    else if (from <= cesv_pkg::SEC_SIG_LEN && flags_q[4]) enter_fixed(cesv_pkg::SEC_SIG_LEN);
    else if (from <= cesv_pkg::SEC_WIT_LEN && flags_q[5]) enter_fixed(cesv_pkg::SEC_WIT_LEN);
    else if (from <= cesv_pkg::SEC_PRIV && flags_q[1]) enter_fixed(cesv_pkg::SEC_PRIV);
    else if (from <= cesv_pkg::SEC_PUB && flags_q[2]) enter_fixed(cesv_pkg::SEC_PUB);
    else close_input();
  endtask

  task automatic go_inputs();
    if (n_in != 0) enter_fixed(cesv_pkg::SEC_TXID);
    else go_after_inputs();
  endtask

  task automatic field_complete(input logic [4:0] p);
    logic [15:0] c16;
    c16 = acc_q[15:0];
    case (p)
      cesv_pkg::SEC_VERSION: begin
        if (acc_q == 32'd1 || acc_q == 32'd2) begin
          ver_q = acc_q[1:0];
          enter_fixed(cesv_pkg::SEC_SEED);
        end else begin
          reject(cesv_pkg::ST_VERSION);
        end
      end
      cesv_pkg::SEC_SEED: enter_fixed(cesv_pkg::SEC_FLAGS);
      cesv_pkg::SEC_FLAGS: begin
        flags_q = acc_q[8:0];
        bad_q = (ver_q == 2'd1) ? (acc_q[31:3] != 0) : (acc_q[31:9] != 0);
        enter_fixed(cesv_pkg::SEC_INCNT);
      end
      cesv_pkg::SEC_INCNT: begin
        n_in = c16;
        enter_fixed(cesv_pkg::SEC_OUTCNT);
      end
      cesv_pkg::SEC_OUTCNT: begin
        if (ver_q == 2'd1) begin
          if (bad_q) reject(cesv_pkg::ST_FLAGS);
          else go_inputs();
        end else begin
          n_grp = c16;
          enter_fixed(cesv_pkg::SEC_SCANCNT);
        end
      end
      cesv_pkg::SEC_SCANCNT: begin
        n_scan = c16;
        enter_fixed(cesv_pkg::SEC_HLABCNT);
      end
      cesv_pkg::SEC_HLABCNT: begin
        n_lab = c16;
        if (bad_q) reject(cesv_pkg::ST_FLAGS);
        else if (!flags_q[6] && n_grp != 0) reject(cesv_pkg::ST_GRP_CNT);
        else if (!flags_q[7] && n_scan != 0) reject(cesv_pkg::ST_SCAN_CNT);
        else if (!flags_q[8] && n_lab != 0) reject(cesv_pkg::ST_LAB_CNT);
        else go_inputs();
      end
      cesv_pkg::SEC_TXID: enter_fixed(cesv_pkg::SEC_VOUT);
      cesv_pkg::SEC_VOUT: enter_fixed(cesv_pkg::SEC_ITYPE);
      cesv_pkg::SEC_ITYPE: begin
        if (acc_q >= 32'd1 && acc_q <= ((ver_q == 2'd1) ? 32'd3 : 32'd4))
          next_in_field(cesv_pkg::SEC_PREV_LEN);
        else
          reject(cesv_pkg::ST_TYPE);
      end
      cesv_pkg::SEC_PREV_LEN, cesv_pkg::SEC_SIG_LEN, cesv_pkg::SEC_WIT_LEN: begin
        // A zero length prefix skips the body and goes straight to the next field.
        if (c16 != 0) enter(p + 5'd1, c16);
        else next_in_field(p + 5'd2);
      end
      cesv_pkg::SEC_PREV, cesv_pkg::SEC_SIG, cesv_pkg::SEC_WIT: next_in_field(p + 5'd1);
      cesv_pkg::SEC_PRIV: next_in_field(cesv_pkg::SEC_PUB);
      cesv_pkg::SEC_PUB: begin
        if (bad_q) reject(cesv_pkg::ST_IN_KEY);
        else close_input();
      end
      cesv_pkg::SEC_SCANPUB: enter_fixed(cesv_pkg::SEC_SPENDPUB);
      cesv_pkg::SEC_SPENDPUB: begin
        if (ver_q == 2'd1) begin
          if (bad_q) reject(cesv_pkg::ST_V1_KEY);
          else enter_fixed(cesv_pkg::SEC_V1LABCNT);
        end else begin
          enter_fixed(cesv_pkg::SEC_RCPTCNT);
        end
      end
      cesv_pkg::SEC_RCPTCNT: begin
        if (bad_q) reject(cesv_pkg::ST_V2_KEY);
        else if (c16 == 0) reject(cesv_pkg::ST_ZERO_RCPT);
        else begin
          n_grp = n_grp - 16'd1;
          if (n_grp != 0) begin
            bad_q = 1'b0;
            enter_fixed(cesv_pkg::SEC_SCANPUB);
          end else begin
            go_after_groups();
          end
        end
      end
      cesv_pkg::SEC_OUTKEY: begin
        n_scan = n_scan - 16'd1;
        if (n_scan != 0) enter_fixed(cesv_pkg::SEC_OUTKEY);
        else go_after_scans();
      end
      cesv_pkg::SEC_SCANPRIV: enter_fixed(cesv_pkg::SEC_SPENDPRIV);
      cesv_pkg::SEC_SPENDPRIV: go_labels();
      cesv_pkg::SEC_V1LABCNT: begin
        n_lab = c16;
        go_labels();
      end
      cesv_pkg::SEC_LABEL: begin
        n_lab = n_lab - 16'd1;
        if (n_lab != 0) enter_fixed(cesv_pkg::SEC_LABEL);
        else ph_q = cesv_pkg::SEC_END;
      end
      default: ph_q = cesv_pkg::SEC_END;
    endcase
  endtask

  // Computes the result item for one accepted byte and advances the shadow parser.
  task automatic predict_byte(input logic [7:0] b, input logic last,
                              output cesv_pkg::result_t r);
    logic [4:0]  sec;
    logic [15:0] off;
    logic [3:0]  st;
    bit          badkey;
    sec = cesv_pkg::SEC_END;
    off = '0;
    if (err_q != cesv_pkg::ST_BUSY || ph_q >= cesv_pkg::SEC_END) begin
      // The first byte past a complete envelope is a trailing-byte error.
      if (err_q == cesv_pkg::ST_BUSY) reject(cesv_pkg::ST_TRAILING);
    end else begin
      sec = ph_q;
      off = pos_q;
      if (off < 16'd4) acc_q = acc_q | (32'(b) << (8 * off));
      if (off == 16'd0) begin
        badkey = !(b == 8'h02 || b == 8'h03);
        if (ph_q == cesv_pkg::SEC_PUB || ph_q == cesv_pkg::SEC_SCANPUB) bad_q = badkey;
        else if (ph_q == cesv_pkg::SEC_SPENDPUB) bad_q = bad_q || badkey;
      end
      pos_q = pos_q + 16'd1;
      left_q = left_q - 16'd1;
      if (left_q == 0) field_complete(sec);
    end
    st = err_q;
    if (last && st == cesv_pkg::ST_BUSY)
      st = (ph_q >= cesv_pkg::SEC_END) ? cesv_pkg::ST_OK : cesv_pkg::ST_EARLY;
    r.status = st;
    r.section = sec;
    r.offset = off;
    r.value = b;
    r.done = last;
    if (last) parser_clear();
  endtask

  // Envelope builder helpers.
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) add_env(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) add_env(8'($urandom));
  endtask

  task automatic put_key();
    // Mostly a valid compressed-key prefix, now and then any byte.
    if ($urandom_range(0, 15) == 0) put_rand(1);
    else add_env(8'($urandom_range(2, 3)));
    put_rand(32);
  endtask

  task automatic flush_packet();
    for (int i = 0; i < env_buf.size(); i++)
      add_pending({(i == env_buf.size() - 1) ? 1'b1 : 1'b0, env_buf[i]});
    env_buf.delete();
  endtask

  task automatic build_envelope();
    int          ver, nin, ngrp, nscan, nlab, len, rc, cut;
    logic [31:0] fl;
    ver = $urandom_range(1, 2);
    put_le(ver, 1);
    put_rand(8);
    fl = (ver == 1) ? $urandom_range(0, 7) : $urandom_range(0, 511);
    if ($urandom_range(0, 15) == 0) fl[$urandom_range(3, 31)] = 1'b1;
    put_le(fl, 4);
    nin = $urandom_range(0, 2);
    put_le(nin, 2);
    ngrp = 0; nscan = 0; nlab = 0;
    if (ver == 1) begin
      put_le($urandom, 2);
    end else begin
      ngrp = (fl[6] || $urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 0;
      nscan = (fl[7] || $urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 0;
      nlab = (fl[8] || $urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 0;
      put_le(ngrp, 2);
      put_le(nscan, 2);
      put_le(nlab, 2);
    end
    for (int k = 0; k < nin; k++) begin
      put_rand(36);
      if ($urandom_range(0, 15) == 0) put_rand(1);
      else put_le($urandom_range(1, (ver == 1) ? 3 : 4), 1);
      for (int bitn = 3; bitn <= 5; bitn++) begin
        if (fl[bitn]) begin
          len = $urandom_range(0, 3);
          put_le(len, 2);
          put_rand(len);
        end
      end
      if (fl[1]) put_rand(32);
      if (fl[2]) put_key();
    end
    if (ver == 1) begin
      put_key();
      put_key();
      nlab = $urandom_range(0, 2);
      put_le(nlab, 2);
      put_rand(4 * nlab);
    end else begin
      if (fl[6]) begin
        for (int g = 0; g < ngrp; g++) begin
          put_key();
          put_key();
          rc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
          put_le(rc, 2);
        end
      end
      if (fl[7]) put_rand(32 * nscan);
      if (fl[8]) begin
        put_rand(64);
        put_rand(4 * nlab);
      end
    end
    // Damage some envelopes: a byte replaced at random, an early cut or extra bytes at the end.
    case ($urandom_range(0, 9))
      0: env_buf[$urandom_range(0, env_buf.size() - 1)] = 8'($urandom);
      1: begin
        cut = $urandom_range(1, env_buf.size() - 1);
        while (env_buf.size() > cut) void'(env_buf.pop_back());
      end
      2: put_rand($urandom_range(1, 3));
      default: ;
    endcase
    flush_packet();
  endtask

  initial begin
    parser_clear();
    // Directed part: bad versions at both extremes, early ends and bytes after an error.
    add_pending({1'b1, 8'h00});
    add_pending({1'b1, 8'hFF});
    add_pending({1'b1, 8'h03});
    add_pending({1'b1, 8'h01});
    add_pending({1'b0, 8'h02});
    add_pending({1'b1, 8'hFF});
    add_pending({1'b0, 8'h00});
    add_pending({1'b0, 8'h7F});
    add_pending({1'b1, 8'h80});
    // Random part: mostly well-formed envelopes with random content, some raw noise.
    while (byte_q.size() < 560) begin
      if ($urandom_range(0, 9) == 0) begin
        put_rand($urandom_range(1, 8));
        flush_packet();
      end else begin
        build_envelope();
      end
    end
    n_queued = byte_q.size();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idling pattern shared by both sides: a quiet window with no idling at all.
  function automatic bit want_idle();
    if (n_cycles >= 300 && n_cycles < 600) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  // Driver: unless it idles, offers the next pending byte whenever the current one is taken or none is shown.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      n_cycles <= n_cycles + 1;
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (byte_q.size() != 0 && !want_idle()) begin
          s_axis_tvalid_i <= 1'b1;
          {s_axis_tlast_i, s_axis_tdata_i} <= byte_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= !want_idle();
    end
  end

  // Monitor: predicts on each accepted input item and checks each accepted result item.
  always @(posedge clk_i) begin
    cesv_pkg::result_t r, e;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_byte(s_axis_tdata_i, s_axis_tlast_i, r);
        expected_q.insert(expected_q.size(), r);
        n_accepted <= n_accepted + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result item: tdata=%h tlast=%b", m_axis_tdata_o,
                     m_axis_tlast_o);
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata_o[3:0] !== e.status || m_axis_tdata_o[8:4] !== e.section ||
              m_axis_tdata_o[24:9] !== e.offset || m_axis_tdata_o[32:25] !== e.value ||
              m_axis_tdata_o[39:33] !== 7'd0 || m_axis_tlast_o !== e.done) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected st=%0d sec=%0d off=%0d val=%h done=%b, %s%h %s%b",
                       e.status, e.section, e.offset, e.value, e.done,
                       "got tdata=", m_axis_tdata_o, "tlast=", m_axis_tlast_o);
          end
        end
      end
    end
  end

  initial begin
    wait (rst_ni && n_queued != 0);
    wait (n_accepted == n_queued);
    wait (expected_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("case_envelope_stream_validator_top_tb: clean");
    else
      $display("case_envelope_stream_validator_top_tb: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("case_envelope_stream_validator_top_tb: errors");
    $finish;
  end

endmodule
